// File: hw/rtl/slot_table_with_tree_order_walk_top_assert.svh
`ifndef SLOT_TABLE_WITH_TREE_ORDER_WALK_TOP_ASSERT_SVH
`define SLOT_TABLE_WITH_TREE_ORDER_WALK_TOP_ASSERT_SVH

// implication, not checked while reset is asserted
`define STWT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stwt: implication check failed");

// plain condition, checked on every edge including reset
`define STWT_ASSERT_ALWAYS(label, clk, cond) \
    label: assert property (@(posedge clk) (cond)) \
        else $error("stwt: condition check failed");

`endif

// File: hw/rtl/stwt_pkg.sv
`timescale 1ns / 1ps

package stwt_pkg;

    localparam int KEY_W       = 64;
    localparam int PRICE_W     = 32;
    localparam int MIN_W       = 16;
    localparam int SLOT_W      = 5;
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_SEARCH = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_PRE    = 3'd3;
    localparam logic [2:0] OP_IN     = 3'd4;
    localparam logic [2:0] OP_POST   = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_FIND   = 2'd1;
    localparam logic [1:0] KIND_WALK   = 2'd2;

    // order codes equal the walk phase at which a node is listed
    localparam logic [1:0] ORD_PRE  = 2'd0;
    localparam logic [1:0] ORD_IN   = 2'd1;
    localparam logic [1:0] ORD_POST = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic       del;
        logic [1:0] order;
    } cls_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [SLOT_W-1:0]  slot;
        logic [KEY_W-1:0]   key;
        logic [PRICE_W-1:0] price;
        logic [MIN_W-1:0]   minutes;
        logic               last;
    } result_t;

    localparam int CLS_W = $bits(cls_t);

endpackage

// File: hw/rtl/slot_table_with_tree_order_walk_top.sv
`timescale 1ns / 1ps

// Slot table of SLOTS records with insert, search, delete and three ordered
// tree dumps (slot i has children 2i+1 and 2i+2).
// Command channel: a word (operation, key, price, flight_minutes) is taken at
// a clock edge with start high and busy low. Unknown operation codes are
// taken and dropped. A two-word queue sits between the decode front and the
// execution back, so busy only rises when two commands are waiting.
// Result channel: each word is on the result ports for one cycle with
// result_strobe high; last marks the final word of a command. The receiver
// cannot stall the block.
// Sequence: insert scans the slots from 0 and fills the first free one; search
// or delete read the slots in order and answer on the first hit, a miss after
// the last slot. A dump steps each tree node through its left, right and up
// phases, one record read from the read port of the record store per listed
// node. The next command is taken from the queue once the back is idle again.
// Reset empties every slot and the queue; no clearing pass is needed, the
// record store is only used where a slot is occupied.
module slot_table_with_tree_order_walk_top #(
    parameter int SLOTS    = 32,
    parameter int KEY_BITS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    operation,
    input  logic [stwt_pkg::KEY_W-1:0]    key,
    input  logic [stwt_pkg::PRICE_W-1:0]  price,
    input  logic [stwt_pkg::MIN_W-1:0]    flight_minutes,
    output logic                          result_strobe,
    output logic [1:0]                    status,
    output logic [stwt_pkg::SLOT_W-1:0]   slot_index,
    output logic [stwt_pkg::KEY_W-1:0]    record_key,
    output logic [stwt_pkg::PRICE_W-1:0]  record_price,
    output logic [stwt_pkg::MIN_W-1:0]    record_minutes,
    output logic                          last
);
    import stwt_pkg::*;

    localparam int QW = CLS_W + KEY_BITS + PRICE_W + MIN_W;

    logic          push, pop, q_full, q_empty;
    logic [QW-1:0] push_data, pop_data;
    result_t       res;

    stwt_front #(
        .KEY_BITS (KEY_BITS)
    ) u_front (
        .start          (start),
        .operation      (operation),
        .key            (key),
        .price          (price),
        .flight_minutes (flight_minutes),
        .q_full         (q_full),
        .busy           (busy),
        .push           (push),
        .push_data      (push_data)
    );

    stwt_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .pop_data  (pop_data)
    );

    stwt_back #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (pop_data),
        .q_pop     (pop),
        .res_valid (result_strobe),
        .res       (res)
    );

    assign status         = res.status;
    assign slot_index     = res.slot;
    assign record_key     = res.key;
    assign record_price   = res.price;
    assign record_minutes = res.minutes;
    assign last           = res.last;

endmodule

// File: hw/rtl/stwt_front.sv
`timescale 1ns / 1ps

module stwt_front #(
    parameter int KEY_BITS = 64
) (
    input  logic                        start,
    input  logic [2:0]                  operation,
    input  logic [stwt_pkg::KEY_W-1:0]  key,
    input  logic [stwt_pkg::PRICE_W-1:0] price,
    input  logic [stwt_pkg::MIN_W-1:0]  flight_minutes,
    input  logic                        q_full,
    output logic                        busy,
    output logic                        push,
    output logic [stwt_pkg::CLS_W+KEY_BITS+stwt_pkg::PRICE_W+stwt_pkg::MIN_W-1:0] push_data
);
    import stwt_pkg::*;

    cls_t cls;
    logic known;

    always_comb
    begin
        cls   = '0;
        known = 1'b1;
        case (operation)
            OP_INSERT:
            begin
                cls.kind = KIND_INSERT;
            end
            OP_SEARCH:
            begin
                cls.kind = KIND_FIND;
            end
            OP_DELETE:
            begin
                cls.kind = KIND_FIND;
                cls.del  = 1'b1;
            end
            OP_PRE:
            begin
                cls.kind  = KIND_WALK;
                cls.order = ORD_PRE;
            end
            OP_IN:
            begin
                cls.kind  = KIND_WALK;
                cls.order = ORD_IN;
            end
            OP_POST:
            begin
                cls.kind  = KIND_WALK;
                cls.order = ORD_POST;
            end
            default:
            begin
                known = 1'b0;   // unknown codes are taken and dropped
            end
        endcase
    end

    assign busy      = q_full;
    assign push      = start && !q_full && known;
    assign push_data = {cls, key[KEY_BITS-1:0], price, flight_minutes};

endmodule

// File: hw/rtl/stwt_fifo.sv
`timescale 1ns / 1ps

module stwt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             full,
    output logic             empty,
    output logic [WIDTH-1:0] pop_data
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] buf_reg [DEPTH];
    logic [AW-1:0]    wptr_reg, wptr_next;
    logic [AW-1:0]    rptr_reg, rptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full     = (cnt_reg == CW'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = buf_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            buf_reg[wptr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/stwt_back.sv
`timescale 1ns / 1ps

module stwt_back #(
    parameter int SLOTS    = 32,
    parameter int KEY_BITS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  logic [stwt_pkg::CLS_W+KEY_BITS+stwt_pkg::PRICE_W+stwt_pkg::MIN_W-1:0] q_data,
    output logic                q_pop,
    output logic                res_valid,
    output stwt_pkg::result_t   res
);
    import stwt_pkg::*;

    localparam int IW  = $clog2(SLOTS);
    localparam int CHW = IW + 2;
    localparam int SD  = $clog2(SLOTS + 1);
    localparam int SIW = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_INS  = 2'd1;
    localparam logic [1:0] S_FIND = 2'd2;
    localparam logic [1:0] S_WALK = 2'd3;

    localparam logic [1:0] PH_LEFT  = 2'd0;
    localparam logic [1:0] PH_RIGHT = 2'd1;
    localparam logic [1:0] PH_UP    = 2'd2;

    function automatic logic [SLOT_W-1:0] slot5(input logic [IW-1:0] i);
        logic [IW+SLOT_W-1:0] w;
        w = (IW + SLOT_W)'(i);
        return w[SLOT_W-1:0];
    endfunction

    cls_t                q_cls;
    logic [KEY_BITS-1:0] q_key;
    logic [PRICE_W-1:0]  q_price;
    logic [MIN_W-1:0]    q_min;

    assign {q_cls, q_key, q_price, q_min} = q_data;

    // record store
    logic [KEY_BITS-1:0] key_mem   [SLOTS];
    logic [PRICE_W-1:0]  price_mem [SLOTS];
    logic [MIN_W-1:0]    min_mem   [SLOTS];
    logic [KEY_BITS-1:0] rd_key_reg;
    logic [PRICE_W-1:0]  rd_price_reg;
    logic [MIN_W-1:0]    rd_min_reg;
    logic                we;
    logic [IW-1:0]       wa, ra;

    logic [1:0]          state_reg, state_next;
    logic [IW-1:0]       scan_reg, scan_next;
    logic                scan_done_reg, scan_done_next;
    logic                rd_find_reg, rd_find_next;
    logic                rd_walk_reg, rd_walk_next;
    logic [IW-1:0]       rd_idx_reg, rd_idx_next;
    logic [SLOTS-1:0]    occ_reg, occ_next;
    logic [SPW-1:0]      sp_reg, sp_next;
    logic [IW-1:0]       stk_node_reg [SD];
    logic [IW-1:0]       stk_node_next [SD];
    logic [1:0]          stk_ph_reg [SD];
    logic [1:0]          stk_ph_next [SD];
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                pend_valid_reg, pend_valid_next;
    result_t             pend_reg, pend_next;
    logic                res_valid_reg, res_valid_next;
    result_t             res_reg, res_next;

    logic                cmd_del_reg;
    logic [1:0]          cmd_order_reg;
    logic [KEY_BITS-1:0] cmd_key_reg;
    logic [PRICE_W-1:0]  cmd_price_reg;
    logic [MIN_W-1:0]    cmd_min_reg;

    logic [SIW-1:0]      top_idx, push_idx;
    logic [IW-1:0]       top_node;
    logic [1:0]          top_ph;
    logic [CHW-1:0]      child_l, child_r;
    logic                left_ok, right_ok;
    result_t             rd_rec;

    assign top_idx  = SIW'(sp_reg - SPW'(1));
    assign push_idx = SIW'(sp_reg);
    assign top_node = stk_node_reg[top_idx];
    assign top_ph   = stk_ph_reg[top_idx];
    assign child_l  = (CHW'(top_node) << 1) + CHW'(1);
    assign child_r  = (CHW'(top_node) << 1) + CHW'(2);
    assign left_ok  = (child_l < CHW'(SLOTS)) && occ_reg[child_l[IW-1:0]];
    assign right_ok = (child_r < CHW'(SLOTS)) && occ_reg[child_r[IW-1:0]];

    always_comb
    begin
        rd_rec         = '0;
        rd_rec.status  = ST_OK;
        rd_rec.slot    = slot5(rd_idx_reg);
        rd_rec.key     = KEY_W'(rd_key_reg);
        rd_rec.price   = rd_price_reg;
        rd_rec.minutes = rd_min_reg;
        rd_rec.last    = 1'b0;
    end

    always_comb
    begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        scan_done_next  = scan_done_reg;
        rd_find_next    = 1'b0;
        rd_walk_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        occ_next        = occ_reg;
        sp_next         = sp_reg;
        stk_node_next   = stk_node_reg;
        stk_ph_next     = stk_ph_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        res_valid_next  = 1'b0;
        res_next        = res_reg;
        q_pop           = 1'b0;
        we              = 1'b0;
        wa              = scan_reg;
        ra              = scan_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop           = 1'b1;
                    scan_next       = '0;
                    scan_done_next  = 1'b0;
                    cnt_next        = '0;
                    pend_valid_next = 1'b0;
                    case (q_cls.kind)
                        KIND_INSERT:
                        begin
                            state_next = S_INS;
                        end
                        KIND_FIND:
                        begin
                            state_next = S_FIND;
                        end
                        KIND_WALK:
                        begin
                            state_next = S_WALK;
                            if (occ_reg[0])
                            begin
                                stk_node_next[0] = '0;
                                stk_ph_next[0]   = PH_LEFT;
                                sp_next          = SPW'(1);
                            end
                            else
                            begin
                                sp_next = '0;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_INS:
            begin
                if (!occ_reg[scan_reg])
                begin
                    we                = 1'b1;
                    wa                = scan_reg;
                    occ_next[scan_reg] = 1'b1;
                    res_valid_next    = 1'b1;
                    res_next.status   = ST_OK;
                    res_next.slot     = slot5(scan_reg);
                    res_next.key      = KEY_W'(cmd_key_reg);
                    res_next.price    = cmd_price_reg;
                    res_next.minutes  = cmd_min_reg;
                    res_next.last     = 1'b1;
                    state_next        = S_IDLE;
                end
                else if (scan_reg == IW'(SLOTS - 1))
                begin
                    res_valid_next  = 1'b1;
                    res_next        = '0;
                    res_next.status = ST_FULL;
                    res_next.last   = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + IW'(1);
                end
            end

            S_FIND:
            begin
                // address issue runs one slot ahead of the key compare
                if (!scan_done_reg)
                begin
                    ra           = scan_reg;
                    rd_find_next = 1'b1;
                    rd_idx_next  = scan_reg;
                    if (scan_reg == IW'(SLOTS - 1))
                    begin
                        scan_done_next = 1'b1;
                    end
                    else
                    begin
                        scan_next = scan_reg + IW'(1);
                    end
                end
                if (rd_find_reg)
                begin
                    if (occ_reg[rd_idx_reg] && rd_key_reg == cmd_key_reg)
                    begin
                        res_valid_next = 1'b1;
                        res_next       = rd_rec;
                        res_next.last  = 1'b1;
                        if (cmd_del_reg)
                        begin
                            occ_next[rd_idx_reg] = 1'b0;
                        end
                        state_next   = S_IDLE;
                        rd_find_next = 1'b0;
                    end
                    else if (rd_idx_reg == IW'(SLOTS - 1))
                    begin
                        res_valid_next  = 1'b1;
                        res_next        = '0;
                        res_next.status = ST_NOT_FOUND;
                        res_next.last   = 1'b1;
                        state_next      = S_IDLE;
                        rd_find_next    = 1'b0;
                    end
                end
            end

            S_WALK:
            begin
                // one record held back so the final word can carry last
                if (rd_walk_reg)
                begin
                    if (pend_valid_reg)
                    begin
                        res_valid_next = 1'b1;
                        res_next       = pend_reg;
                    end
                    pend_valid_next = 1'b1;
                    pend_next       = rd_rec;
                end

                if (sp_reg != '0 && cnt_reg != CNT_W'(MAX_RESULTS))
                begin
                    if (top_ph == cmd_order_reg)
                    begin
                        ra           = top_node;
                        rd_walk_next = 1'b1;
                        rd_idx_next  = top_node;
                        cnt_next     = cnt_reg + CNT_W'(1);
                    end
                    case (top_ph)
                        PH_LEFT:
                        begin
                            stk_ph_next[top_idx] = PH_RIGHT;
                            if (left_ok)
                            begin
                                stk_node_next[push_idx] = child_l[IW-1:0];
                                stk_ph_next[push_idx]   = PH_LEFT;
                                sp_next                 = sp_reg + SPW'(1);
                            end
                        end
                        PH_RIGHT:
                        begin
                            stk_ph_next[top_idx] = PH_UP;
                            if (right_ok)
                            begin
                                stk_node_next[push_idx] = child_r[IW-1:0];
                                stk_ph_next[push_idx]   = PH_LEFT;
                                sp_next                 = sp_reg + SPW'(1);
                            end
                        end
                        default:
                        begin
                            sp_next = sp_reg - SPW'(1);
                        end
                    endcase
                end
                else if (!rd_walk_reg)
                begin
                    res_valid_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        res_next      = pend_reg;
                        res_next.last = 1'b1;
                    end
                    else
                    begin
                        res_next        = '0;
                        res_next.status = ST_EMPTY;
                        res_next.last   = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_reg       <= '0;
            scan_done_reg  <= 1'b0;
            rd_find_reg    <= 1'b0;
            rd_walk_reg    <= 1'b0;
            rd_idx_reg     <= '0;
            occ_reg        <= '0;
            sp_reg         <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_reg       <= scan_next;
            scan_done_reg  <= scan_done_next;
            rd_find_reg    <= rd_find_next;
            rd_walk_reg    <= rd_walk_next;
            rd_idx_reg     <= rd_idx_next;
            occ_reg        <= occ_next;
            sp_reg         <= sp_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stk_node_reg <= stk_node_next;
        stk_ph_reg   <= stk_ph_next;
        pend_reg     <= pend_next;
        res_reg      <= res_next;
        if (q_pop)
        begin
            cmd_del_reg   <= q_cls.del;
            cmd_order_reg <= q_cls.order;
            cmd_key_reg   <= q_key;
            cmd_price_reg <= q_price;
            cmd_min_reg   <= q_min;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem[wa]   <= cmd_key_reg;
            price_mem[wa] <= cmd_price_reg;
            min_mem[wa]   <= cmd_min_reg;
        end
        rd_key_reg   <= key_mem[ra];
        rd_price_reg <= price_mem[ra];
        rd_min_reg   <= min_mem[ra];
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: hw/rtl/stwt_checker.sv
`timescale 1ns / 1ps

`include "slot_table_with_tree_order_walk_top_assert.svh"

module stwt_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          result_strobe,
    input  logic [1:0]                    status,
    input  logic [stwt_pkg::SLOT_W-1:0]   slot_index,
    input  logic [stwt_pkg::KEY_W-1:0]    record_key,
    input  logic [stwt_pkg::PRICE_W-1:0]  record_price,
    input  logic [stwt_pkg::MIN_W-1:0]    record_minutes,
    input  logic                          last
);
    import stwt_pkg::*;

    logic fields_zero;

    assign fields_zero = (slot_index == '0) && (record_key == '0) &&
                         (record_price == '0) && (record_minutes == '0);

    // no word comes out while reset is held; the strobe may be unknown
    // before the first edge of reset
    `STWT_ASSERT_ALWAYS(a_reset_quiet, clk, rst_n || result_strobe !== 1'b1)

    // full, not-found and empty-dump answers are single words
    `STWT_ASSERT_IMP(a_err_last, clk, rst_n, result_strobe && status != ST_OK, last)

    `STWT_ASSERT_IMP(a_err_zero, clk, rst_n, result_strobe && status != ST_OK, fields_zero)

    // the queue only fills through a command taken on the edge before
    `STWT_ASSERT_IMP(a_busy_cause, clk, rst_n, $rose(busy), $past(start))

endmodule

bind slot_table_with_tree_order_walk_top stwt_checker u_stwt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .result_strobe  (result_strobe),
    .status         (status),
    .slot_index     (slot_index),
    .record_key     (record_key),
    .record_price   (record_price),
    .record_minutes (record_minutes),
    .last           (last)
);
